// ===== rtl/wfd_pkg.sv =====
// Shared types and constants for the frame decoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package wfd_pkg;

    localparam int MASK_BYTES = 4;
    localparam int KEY_IDX_W  = $clog2(MASK_BYTES);
    localparam int HDR_IDX_W  = 3;
    localparam int LEN_W      = 32;
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);
    localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] FB_TEXT  = 8'h81;
    localparam logic [7:0] FB_CLOSE = 8'h88;
    localparam logic [7:0] FB_PING  = 8'h89;
    localparam logic [7:0] FB_PONG  = 8'h8a;
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    localparam logic [HDR_IDX_W-1:0] EXT16_LAST = HDR_IDX_W'(1);
    localparam logic [HDR_IDX_W-1:0] EXT64_LAST = HDR_IDX_W'(7);
    localparam logic [HDR_IDX_W-1:0] MASK_LAST  = HDR_IDX_W'(MASK_BYTES - 1);

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_FIRST = 2'd1,
        ST_TRUNCATED = 2'd2,
        ST_OVERLONG  = 2'd3
    } t_status;

    typedef enum logic [6:0] {
        PH_FIRST   = 7'b0000001,
        PH_LEN7    = 7'b0000010,
        PH_EXT16   = 7'b0000100,
        PH_EXT64   = 7'b0001000,
        PH_MASK    = 7'b0010000,
        PH_PAYLOAD = 7'b0100000,
        PH_SKIP    = 7'b1000000
    } t_phase;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic             byte_valid;
        logic             frame_end;
        t_status          status;
        logic [3:0]       opcode;
        logic             is_close;
        logic [LEN_W-1:0] payload_length;
    } t_result;

    typedef struct packed {
        logic               full;
        logic               empty;
        logic [Q_CNT_W-1:0] count;
    } t_q_status;

endpackage

// ===== rtl/websocket_frame_decoder.sv =====
// Top level of the frame decoder: parser, result queue and output stage.
// Depends on wfd_pkg, wfd_front, wfd_queue, wfd_back.
//
//  channel  | dir | tdata                                   | tlast        | tuser
//  s_axis   | in  | in_byte                                 | buffer_last  | -
//  m_axis   | out | out_byte,status,opcode,is_close,length  | frame_end    | byte_valid
//
// One byte is taken every cycle while the 4-word result queue has room.
// A result word is written into the result queue when its byte is taken and reaches m_axis through the output register.
// s_axis_tready drops only when the queue is full, i.e. after m_axis stalls.
// Reset is synchronous on i_rst_n and leaves the parser at a frame start
// with the queue and output register empty.
`timescale 1ns / 1ps

module websocket_frame_decoder import wfd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] out_byte, [9:8] status, [13:10] opcode, [14] is_close,
    // [46:15] payload_length, [47] zero
    output logic [47:0] m_axis_tdata,
    output logic        m_axis_tlast,
    output logic        m_axis_tuser    // [0] byte_valid
);

    logic      w_push;
    logic      w_pop;
    t_result   w_item;
    t_result   w_head;
    t_q_status w_q_status;

    assign s_axis_tready = !w_q_status.full;

    wfd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_ready (s_axis_tready),
        .i_byte  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .o_push  (w_push),
        .o_item  (w_item)
    );

    wfd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_item   (w_item),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_q_status)
    );

    wfd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (w_head),
        .i_q_status    (w_q_status),
        .o_pop         (w_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_status.count <= Q_CNT_W'(Q_DEPTH))
        else $error("result queue count beyond depth");

    a_no_empty_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
        else $error("word with neither payload byte nor frame end");

    a_mid_frame_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[47:8] == '0)
        else $error("frame report fields set before frame end");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("output valid or input stalled after reset");

endmodule

// ===== rtl/wfd_front.sv =====
// Header parser and unmasker: classifies each received byte, emits result words.
// Depends on wfd_pkg.
`timescale 1ns / 1ps

module wfd_front import wfd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic       i_ready,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output logic       o_push,
    output t_result    o_item
);

    t_phase                 r_phase, n_phase;
    logic [HDR_IDX_W-1:0]   r_hdr_idx, n_hdr_idx;
    logic [7:0]             r_first_byte, n_first_byte;
    logic                   r_mask_present, n_mask_present;
    logic [7:0]             r_mask_key [MASK_BYTES];
    logic [LEN_W-1:0]       r_length, n_length;
    logic [LEN_W-1:0]       r_count, n_count;
    logic                   r_overlong, n_overlong;

    logic                   w_accept;
    logic                   w_key_we;
    logic                   w_valid;
    logic [7:0]             w_out;
    t_phase                 w_after_len;
    t_status                w_status;

    assign w_accept    = i_valid && i_ready;
    assign w_after_len = n_mask_present ? PH_MASK : PH_PAYLOAD;

    always_comb begin
        n_phase        = r_phase;
        n_hdr_idx      = r_hdr_idx;
        n_first_byte   = r_first_byte;
        n_mask_present = r_mask_present;
        n_length       = r_length;
        n_count        = r_count;
        n_overlong     = r_overlong;
        w_key_we       = 1'b0;
        w_valid        = 1'b0;
        w_out          = 8'h00;
        unique case (r_phase)
            PH_FIRST: begin
                n_first_byte = i_byte;
                if (i_byte == FB_TEXT || i_byte == FB_CLOSE ||
                    i_byte == FB_PING || i_byte == FB_PONG) begin
                    n_phase = PH_LEN7;
                end else begin
                    n_phase = PH_SKIP;
                end
            end
            PH_LEN7: begin
                n_mask_present = i_byte[7];
                n_hdr_idx      = '0;
                n_length       = '0;
                if (i_byte[6:0] == LEN_EXT16) begin
                    n_phase = PH_EXT16;
                end else if (i_byte[6:0] == LEN_EXT64) begin
                    n_phase = PH_EXT64;
                end else begin
                    n_length = LEN_W'(i_byte[6:0]);
                    n_phase  = w_after_len;
                end
            end
            PH_EXT16, PH_EXT64: begin
                // shift in; the high half of a 64-bit length falls off the top
                n_length = {r_length[LEN_W-9:0], i_byte};
                if ((r_phase == PH_EXT16 && r_hdr_idx == EXT16_LAST) ||
                    (r_phase == PH_EXT64 && r_hdr_idx == EXT64_LAST)) begin
                    n_hdr_idx = '0;
                    n_phase   = w_after_len;
                end else begin
                    n_hdr_idx = r_hdr_idx + HDR_IDX_W'(1);
                end
            end
            PH_MASK: begin
                w_key_we = 1'b1;
                if (r_hdr_idx == MASK_LAST) begin
                    n_hdr_idx = '0;
                    n_phase   = PH_PAYLOAD;
                end else begin
                    n_hdr_idx = r_hdr_idx + HDR_IDX_W'(1);
                end
            end
            PH_PAYLOAD: begin
                if (r_count < r_length) begin
                    w_valid = 1'b1;
                    w_out   = r_mask_present ?
                              (i_byte ^ r_mask_key[r_count[KEY_IDX_W-1:0]]) : i_byte;
                    n_count = r_count + LEN_W'(1);
                end else begin
                    n_overlong = 1'b1;
                end
            end
            PH_SKIP: begin
                // swallow the rest of a bad frame
            end
            default: begin
                n_phase = PH_FIRST;
            end
        endcase
    end

    always_comb begin
        if (r_phase == PH_FIRST) begin
            w_status = ST_TRUNCATED;
        end else if (n_phase == PH_SKIP) begin
            w_status = ST_BAD_FIRST;
        end else if (n_phase != PH_PAYLOAD) begin
            w_status = ST_TRUNCATED;
        end else if (n_overlong) begin
            w_status = ST_OVERLONG;
        end else if (n_count < n_length) begin
            w_status = ST_TRUNCATED;
        end else begin
            w_status = ST_OK;
        end
    end

    always_comb begin
        o_push              = w_accept && (w_valid || i_last);
        o_item.out_byte     = w_out;
        o_item.byte_valid   = w_valid;
        o_item.frame_end    = i_last;
        o_item.status       = i_last ? w_status : ST_OK;
        o_item.opcode       = i_last ? n_first_byte[3:0] : 4'h0;
        o_item.is_close     = i_last && (n_first_byte == FB_CLOSE);
        o_item.payload_length = i_last ? n_length : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_FIRST;
            r_hdr_idx      <= '0;
            r_first_byte   <= '0;
            r_mask_present <= 1'b0;
            r_length       <= '0;
            r_count        <= '0;
            r_overlong     <= 1'b0;
        end else if (w_accept) begin
            if (i_last) begin
                // end of buffer: back to the start of a frame
                r_phase        <= PH_FIRST;
                r_hdr_idx      <= '0;
                r_first_byte   <= '0;
                r_mask_present <= 1'b0;
                r_length       <= '0;
                r_count        <= '0;
                r_overlong     <= 1'b0;
            end else begin
                r_phase        <= n_phase;
                r_hdr_idx      <= n_hdr_idx;
                r_first_byte   <= n_first_byte;
                r_mask_present <= n_mask_present;
                r_length       <= n_length;
                r_count        <= n_count;
                r_overlong     <= n_overlong;
            end
        end
    end

    // key is always written in full before payload bytes read it
    always_ff @(posedge i_clk) begin
        if (w_accept && w_key_we) begin
            r_mask_key[r_hdr_idx[KEY_IDX_W-1:0]] <= i_byte;
        end
    end

endmodule

// ===== rtl/wfd_queue.sv =====
// Short result queue between parser and output stage.
// Depends on wfd_pkg.
`timescale 1ns / 1ps

module wfd_queue import wfd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_result   i_item,
    input  logic      i_pop,
    output t_result   o_head,
    output t_q_status o_status
);

    t_result              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr;
    logic [Q_CNT_W-1:0]   r_count;

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.count = r_count;
    assign o_status.full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_status.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + Q_CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - Q_CNT_W'(1);
            end
        end
    end

endmodule

// ===== rtl/wfd_back.sv =====
// Output register stage: drains the queue onto the master stream.
// Depends on wfd_pkg.
`timescale 1ns / 1ps

module wfd_back import wfd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_result     i_head,
    input  t_q_status   i_q_status,
    output logic        o_pop,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,
    output logic        m_axis_tlast,
    output logic        m_axis_tuser
);

    logic    r_valid;
    t_result r_item;

    // refill when the register is empty or its word leaves this cycle
    assign o_pop = !i_q_status.empty && (!r_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_head;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tlast  = r_item.frame_end;
    assign m_axis_tuser  = r_item.byte_valid;
    assign m_axis_tdata  = {1'b0, r_item.payload_length, r_item.is_close,
                            r_item.opcode, r_item.status, r_item.out_byte};

endmodule

// ===== test/tb_top.sv =====
// Self-checking bench for websocket_frame_decoder: queued byte stream in, result words out.
// Depends on wfd_pkg and the decoder RTL; expected words come from a local frame decoder model.
`timescale 1ns / 1ps

module tb_top;
    import wfd_pkg::*;

    localparam int N_ITEMS = 850;
    localparam int LIMIT   = 200000;
    localparam int SETTLE  = 8;

    // length encodings of the second header byte
    localparam int FORM_7  = 0;
    localparam int FORM_16 = 1;
    localparam int FORM_64 = 2;

    typedef struct {
        logic [7:0] data;
        logic       last;
        bit         drain;  // wait for every outstanding word before sending
    } t_rx_byte;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;    // [7:0] in_byte
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // [7:0] out_byte, [9:8] status, [13:10] opcode, [14] is_close,
    // [46:15] payload_length, [47] zero
    logic [47:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        m_axis_tuser;    // [0] byte_valid

    websocket_frame_decoder uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    t_rx_byte   rx_bytes [$];
    t_rx_byte   cur_byte;
    bit         byte_held;
    t_result    expected_words [$];

    // decoder model state
    t_phase     dec_phase;
    int         dec_hdr_idx;
    logic [7:0] dec_first;
    logic       dec_masked;
    logic [7:0] dec_key [MASK_BYTES];
    logic [31:0] dec_len;
    logic [31:0] dec_count;
    t_status    dec_err;

    int cycles;
    int n_errors;
    int n_taken;
    int n_words;
    int n_buffers;
    int n_endings [4];
    bit calm;

    always #4 i_clk = ~i_clk;

    task automatic clear_decoder();
        dec_phase   = PH_FIRST;
        dec_hdr_idx = 0;
        dec_first   = 8'h00;
        dec_masked  = 1'b0;
        for (int i = 0; i < MASK_BYTES; i++) dec_key[i] = 8'h00;
        dec_len     = '0;
        dec_count   = '0;
        dec_err     = ST_OK;
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic last);
        t_result w;
        logic    was_first;
        int      need;
        w = '0;
        was_first = (dec_phase == PH_FIRST);
        case (dec_phase)
            PH_FIRST: begin
                dec_first = b;
                if (b == FB_TEXT || b == FB_CLOSE || b == FB_PING || b == FB_PONG) begin
                    dec_phase = PH_LEN7;
                end else begin
                    dec_err   = ST_BAD_FIRST;
                    dec_phase = PH_SKIP;
                end
            end
            PH_LEN7: begin
                dec_masked  = b[7];
                dec_hdr_idx = 0;
                dec_len     = '0;
                if (b[6:0] == LEN_EXT16) begin
                    dec_phase = PH_EXT16;
                end else if (b[6:0] == LEN_EXT64) begin
                    dec_phase = PH_EXT64;
                end else begin
                    dec_len   = {25'd0, b[6:0]};
                    dec_phase = dec_masked ? PH_MASK : PH_PAYLOAD;
                end
            end
            PH_EXT16, PH_EXT64: begin
                need = (dec_phase == PH_EXT16) ? 2 : 8;
                // only the low 32 bits survive the shift
                dec_len = {dec_len[23:0], b};
                dec_hdr_idx++;
                if (dec_hdr_idx >= need) begin
                    dec_hdr_idx = 0;
                    dec_phase   = dec_masked ? PH_MASK : PH_PAYLOAD;
                end
            end
            PH_MASK: begin
                dec_key[dec_hdr_idx % MASK_BYTES] = b;
                dec_hdr_idx++;
                if (dec_hdr_idx >= MASK_BYTES) begin
                    dec_hdr_idx = 0;
                    dec_phase   = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                if (dec_count < dec_len) begin
                    w.out_byte   = b ^ (dec_masked ? dec_key[dec_count % MASK_BYTES] : 8'h00);
                    w.byte_valid = 1'b1;
                    dec_count++;
                end else begin
                    dec_err = ST_OVERLONG;
                end
            end
            default: ;
        endcase

        if (w.byte_valid || last) begin
            if (last) begin
                w.frame_end = 1'b1;
                if (was_first)
                    w.status = ST_TRUNCATED;
                else if (dec_err == ST_BAD_FIRST)
                    w.status = ST_BAD_FIRST;
                else if (dec_phase != PH_PAYLOAD)
                    w.status = ST_TRUNCATED;
                else if (dec_err == ST_OVERLONG)
                    w.status = ST_OVERLONG;
                else if (dec_count < dec_len)
                    w.status = ST_TRUNCATED;
                else
                    w.status = ST_OK;
                w.opcode         = dec_first[3:0];
                w.is_close       = (dec_first == FB_CLOSE);
                w.payload_length = dec_len;
                n_endings[w.status]++;
                clear_decoder();
            end
            expected_words.push_back(w);
        end
    endtask

    task automatic check_word();
        t_result got;
        t_result want;
        got.out_byte       = m_axis_tdata[7:0];
        got.byte_valid     = m_axis_tuser;
        got.frame_end      = m_axis_tlast;
        got.status         = t_status'(m_axis_tdata[9:8]);
        got.opcode         = m_axis_tdata[13:10];
        got.is_close       = m_axis_tdata[14];
        got.payload_length = m_axis_tdata[46:15];
        if (expected_words.size() == 0) begin
            n_errors++;
            $display("%0t: result word with none expected, actual tdata=%h last=%b user=%b",
                     $time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
        end else begin
            want = expected_words.pop_front();
            n_words++;
            if (got !== want || m_axis_tdata[47] !== 1'b0) begin
                n_errors++;
                $display("%0t: mismatch expected byte=%h valid=%b end=%b status=%0d op=%h close=%b len=%0d spare=0",
                         $time, want.out_byte, want.byte_valid, want.frame_end, want.status,
                         want.opcode, want.is_close, want.payload_length);
                $display("%0t:          actual byte=%h valid=%b end=%b status=%0d op=%h close=%b len=%0d spare=%b",
                         $time, got.out_byte, got.byte_valid, got.frame_end, got.status,
                         got.opcode, got.is_close, got.payload_length, m_axis_tdata[47]);
            end
        end
    endtask

    // keep < 0 cuts the buffer at a random point, keep > 0 at that many bytes
    task automatic add_frame(input logic [7:0] fb, input int form, input logic [31:0] len,
                             input logic [31:0] hi, input bit masked, input int npay,
                             input int keep, input bit drain);
        logic [7:0] frame [$];
        logic [6:0] l7;
        int         n;
        l7 = (form == FORM_16) ? LEN_EXT16 : (form == FORM_64) ? LEN_EXT64 : len[6:0];
        frame.push_back(fb);
        frame.push_back({masked, l7});
        if (form == FORM_16) begin
            frame.push_back(len[15:8]);
            frame.push_back(len[7:0]);
        end
        if (form == FORM_64) begin
            for (int i = 3; i >= 0; i--) frame.push_back(hi[8*i +: 8]);
            for (int i = 3; i >= 0; i--) frame.push_back(len[8*i +: 8]);
        end
        if (masked)
            for (int i = 0; i < MASK_BYTES; i++) frame.push_back(8'($urandom));
        for (int i = 0; i < npay; i++) frame.push_back(8'($urandom));
        if (keep < 0)
            n = $urandom_range(frame.size() - 1, 1);
        else if (keep > 0 && keep < frame.size())
            n = keep;
        else
            n = frame.size();
        for (int i = 0; i < n; i++)
            rx_bytes.push_back('{data: frame[i], last: (i == n - 1), drain: (drain && i == 0)});
        n_buffers++;
    endtask

    task automatic build_stimulus();
        logic [7:0]  good_first [4];
        logic [7:0]  fb;
        logic [31:0] len;
        int          pick;
        int          form;
        int          n;
        bit          masked;
        good_first = '{FB_TEXT, FB_CLOSE, FB_PING, FB_PONG};

        // directed: short buffers and each way a frame can end
        add_frame(FB_TEXT,  FORM_7,  0,      0, 0, 0, 1,  0);
        add_frame(8'hff,    FORM_7,  0,      0, 0, 0, 1,  0);
        add_frame(8'h01,    FORM_7,  2,      0, 0, 2, 0,  0);
        add_frame(FB_PONG,  FORM_7,  0,      0, 0, 0, 0,  0);
        add_frame(FB_CLOSE, FORM_16, 16'h012c, 0, 0, 0, 3, 0);
        add_frame(FB_PING,  FORM_7,  3,      0, 1, 3, 0,  0);
        add_frame(FB_CLOSE, FORM_7,  2,      0, 0, 3, 0,  0);
        add_frame(FB_TEXT,  FORM_7,  5,      0, 0, 5, 4,  1);

        while (rx_bytes.size() < N_ITEMS) begin
            pick   = $urandom_range(99);
            fb     = good_first[$urandom_range(3)];
            masked = $urandom_range(1);
            n      = $urandom_range(2);
            form   = (n == 0) ? FORM_7 : (n == 1) ? FORM_16 : FORM_64;
            len    = $urandom_range(12);
            if (pick < 8) begin
                // noise: random bytes, random first byte
                n = $urandom_range(5, 1);
                for (int i = 0; i < n; i++)
                    rx_bytes.push_back('{data: 8'($urandom), last: (i == n - 1), drain: 0});
                n_buffers++;
            end else if (pick < 10) begin
                // longest lengths, cut short inside the payload
                len = (form == FORM_16) ? 32'h0000ffff : 32'hffffffff;
                if (form == FORM_7) len = 125;
                add_frame(fb, form, len, $urandom, masked, $urandom_range(6, 1), 0, 0);
            end else if (pick < 11) begin
                add_frame(fb, FORM_7, 125, 0, masked, 125, 0, 0);
            end else if (pick < 20) begin
                add_frame(fb, form, len, $urandom, masked, len, -1, 0);
            end else if (pick < 28) begin
                add_frame(fb, form, len, $urandom, masked, len + $urandom_range(3, 1), 0, 0);
            end else begin
                add_frame(fb, form, len, $urandom, masked, len,
                          0, (n_buffers == 30 || n_buffers == 90));
            end
        end
    endtask

    // sender: hold a byte until taken, then maybe idle before the next; also drives m_axis_tready
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            calm = (n_taken >= 300 && n_taken < 500);
            if (!byte_held && rx_bytes.size() > 0) begin
                if (rx_bytes[0].drain && expected_words.size() != 0) begin
                    // hold until every outstanding word has come back
                end else if (calm || $urandom_range(99) >= 20) begin
                    cur_byte  = rx_bytes.pop_front();
                    byte_held = 1'b1;
                end
            end
            s_axis_tvalid <= byte_held;
            s_axis_tdata  <= cur_byte.data;
            s_axis_tlast  <= cur_byte.last;
            m_axis_tready <= calm || ($urandom_range(99) >= 20);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("%0t: timed out after %0d cycles", $time, cycles);
            $display("[websocket_frame_decoder] ERROR");
            $finish;
        end else if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                check_word();
            if (s_axis_tvalid && s_axis_tready) begin
                decode_byte(s_axis_tdata, s_axis_tlast);
                byte_held = 1'b0;
                n_taken++;
            end
        end
    end

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        byte_held     = 1'b0;
        cur_byte      = '{data: 8'h00, last: 1'b0, drain: 0};
        cycles        = 0;
        n_errors      = 0;
        n_taken       = 0;
        n_words       = 0;
        n_buffers     = 0;
        n_endings     = '{0, 0, 0, 0};
        calm          = 1'b0;
        clear_decoder();
        build_stimulus();

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (rx_bytes.size() != 0 || byte_held) @(posedge i_clk);
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        $display("sent %0d buffers (%0d bytes), checked %0d result words",
                 n_buffers, n_taken, n_words);
        $display("frame endings: ok %0d, bad first byte %0d, truncated %0d, overlong %0d",
                 n_endings[ST_OK], n_endings[ST_BAD_FIRST], n_endings[ST_TRUNCATED],
                 n_endings[ST_OVERLONG]);
        if (n_errors == 0)
            $display("[websocket_frame_decoder] OK");
        else
            $display("[websocket_frame_decoder] ERROR");
        $finish;
    end

endmodule
